### hdl/quadratic_calculator_alu_macros.svh
// Assertion helpers for the calculator RTL (used by quadratic_calculator_alu).
`ifndef QUADRATIC_CALCULATOR_ALU_MACROS_SVH
`define QUADRATIC_CALCULATOR_ALU_MACROS_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define QCA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define QCA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/qca_pkg.sv
package qca_pkg;

  localparam int DATA_W   = 32;
  localparam int FRAC_W   = 16;
  localparam int CMD_W    = 3;
  localparam int ST_W     = 3;
  localparam int PROD_W   = 2 * DATA_W;
  // b*b + 4*|a*c| needs three bits over a full product
  localparam int DISC_W   = PROD_W + 3;
  localparam int ROOT_W   = (DISC_W + 1) / 2;
  localparam int SQ_IN_W  = 2 * ROOT_W;
  localparam int SQ_REM_W = ROOT_W + 2;
  // root +/- b, signed
  localparam int DIFF_W   = ROOT_W + 2;
  localparam int MAGN_W   = ROOT_W + 1;
  localparam int NUM_W    = MAGN_W + FRAC_W;
  localparam int DEN_W    = DATA_W + 1;
  localparam int DMAG_W   = DISC_W - FRAC_W;
  localparam int SAT_W    = (NUM_W > DMAG_W) ? NUM_W : DMAG_W;

  localparam logic [DATA_W-1:0] MAX_POS = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] MIN_NEG = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD     = 3'd0,
    CMD_SUB     = 3'd1,
    CMD_DIV     = 3'd2,
    CMD_MUL     = 3'd3,
    CMD_DISC    = 3'd4,
    CMD_ROOTS   = 3'd5,
    CMD_SQRT    = 3'd6,
    CMD_INVALID = 3'd7
  } qca_cmd_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 3'd0,
    ST_DIV0    = 3'd1,
    ST_NEGDISC = 3'd2,
    ST_NEGROOT = 3'd3,
    ST_INVALID = 3'd4,
    ST_SAT     = 3'd5
  } qca_status_e;

  // Per-request context that rides along with the arithmetic
  typedef struct packed {
    qca_cmd_e            cmd;
    qca_status_e         st;
    logic                ovf;
    logic                a_neg;
    logic                b_neg;
    logic [DATA_W-1:0]   a_mag;
    logic [DATA_W-1:0]   b_mag;
    logic [DATA_W-1:0]   b_val;
    logic [DATA_W-1:0]   r_first;
    logic [DATA_W-1:0]   dout;
    logic                neg1;
    logic                neg2;
  } qca_side_t;

  typedef struct packed {
    logic [DATA_W-1:0] val;
    logic              ovf;
  } qca_sat_t;

  // Clamp a sign/magnitude value to the signed output range
  function automatic qca_sat_t qca_sat(input logic neg, input logic [SAT_W-1:0] mag);
    qca_sat_t r;
    r.ovf = 1'b0;
    if (!neg) begin
      if (mag > SAT_W'(MAX_POS)) begin
        r.val = MAX_POS;
        r.ovf = 1'b1;
      end else begin
        r.val = mag[DATA_W-1:0];
      end
    end else begin
      if (mag > SAT_W'(MIN_NEG)) begin
        r.val = MIN_NEG;
        r.ovf = 1'b1;
      end else begin
        r.val = (~mag[DATA_W-1:0]) + DATA_W'(1);
      end
    end
    return r;
  endfunction

endpackage

### hdl/qca_front.sv
module qca_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             valid_i,
  input  logic [qca_pkg::CMD_W-1:0]        command_i,
  input  logic signed [qca_pkg::DATA_W-1:0] operand_a_i,
  input  logic signed [qca_pkg::DATA_W-1:0] operand_b_i,
  input  logic signed [qca_pkg::DATA_W-1:0] operand_c_i,
  output logic                             valid_o,
  output qca_pkg::qca_side_t               side_o,
  output logic [qca_pkg::SQ_IN_W-1:0]      sq_x_o
);

  localparam int DATA_W  = qca_pkg::DATA_W;
  localparam int FRAC_W  = qca_pkg::FRAC_W;
  localparam int PROD_W  = qca_pkg::PROD_W;
  localparam int DISC_W  = qca_pkg::DISC_W;
  localparam int SAT_W   = qca_pkg::SAT_W;
  localparam int SQ_IN_W = qca_pkg::SQ_IN_W;

  logic v0_q, v1_q, v2_q, v3_q, v4_q;

  // stage 0: sign/magnitude split
  qca_pkg::qca_cmd_e         cmd0_q;
  logic                      an0_q, bn0_q, cn0_q;
  logic [DATA_W-1:0]         am0_q, bm0_q, cm0_q;
  logic signed [DATA_W-1:0]  a0_q, b0_q;
  logic [DATA_W-1:0]         am_d, bm_d, cm_d;

  // stage 1: products and sums
  qca_pkg::qca_cmd_e         cmd1_q;
  logic                      an1_q, bn1_q, cn1_q;
  logic [DATA_W-1:0]         am1_q, bm1_q, b1_q;
  logic [PROD_W-1:0]         pbb1_q, pab1_q, pac1_q;
  logic signed [DATA_W:0]    sum1_q, dif1_q;

  // stage 2: discriminant terms, simple results
  qca_pkg::qca_cmd_e         cmd2_q;
  logic                      an2_q, bn2_q, qneg2_q, ovf2_q;
  logic [DATA_W-1:0]         am2_q, bm2_q, b2_q, r2_q;
  logic [DISC_W-1:0]         dsum2_q;
  logic [DISC_W:0]           ddif2_q;
  logic [PROD_W+1:0]         q4;
  logic                      sovf, dovf, ovf2_d;
  logic [DATA_W-1:0]         sval, dval, r2_d;
  qca_pkg::qca_sat_t         msat;

  // stage 3: discriminant magnitude
  qca_pkg::qca_cmd_e         cmd3_q;
  logic                      an3_q, bn3_q, ovf3_q, dneg3_q;
  logic [DATA_W-1:0]         am3_q, bm3_q, b3_q, r3_q;
  logic [DISC_W-1:0]         d3_q, d3_d;

  // stage 4: status, discriminant clamp, root operand
  qca_pkg::qca_sat_t         dsat;
  qca_pkg::qca_status_e      st_d;
  qca_pkg::qca_side_t        side_d, side_q;
  logic [SQ_IN_W-1:0]        sq_x_d, sq_x_q;

  assign am_d = operand_a_i[DATA_W-1] ? DATA_W'(-operand_a_i) : DATA_W'(operand_a_i);
  assign bm_d = operand_b_i[DATA_W-1] ? DATA_W'(-operand_b_i) : DATA_W'(operand_b_i);
  assign cm_d = operand_c_i[DATA_W-1] ? DATA_W'(-operand_c_i) : DATA_W'(operand_c_i);

  assign q4    = {pac1_q, 2'b00};
  assign sovf  = sum1_q[DATA_W] ^ sum1_q[DATA_W-1];
  assign dovf  = dif1_q[DATA_W] ^ dif1_q[DATA_W-1];
  assign sval  = sovf ? (sum1_q[DATA_W] ? qca_pkg::MIN_NEG : qca_pkg::MAX_POS)
                      : sum1_q[DATA_W-1:0];
  assign dval  = dovf ? (dif1_q[DATA_W] ? qca_pkg::MIN_NEG : qca_pkg::MAX_POS)
                      : dif1_q[DATA_W-1:0];
  assign msat  = qca_pkg::qca_sat(an1_q ^ bn1_q, SAT_W'(pab1_q[PROD_W-1:FRAC_W]));

  always_comb begin
    r2_d   = '0;
    ovf2_d = 1'b0;
    case (cmd1_q)
      qca_pkg::CMD_ADD: begin
        r2_d   = sval;
        ovf2_d = sovf;
      end
      qca_pkg::CMD_SUB: begin
        r2_d   = dval;
        ovf2_d = dovf;
      end
      qca_pkg::CMD_MUL: begin
        r2_d   = msat.val;
        ovf2_d = msat.ovf;
      end
      default: begin
        r2_d   = '0;
        ovf2_d = 1'b0;
      end
    endcase
  end

  // a negative 4ac term adds; otherwise take |b*b - 4ac|
  assign d3_d = qneg2_q ? dsum2_q
              : (ddif2_q[DISC_W] ? DISC_W'(-ddif2_q) : ddif2_q[DISC_W-1:0]);

  assign dsat = qca_pkg::qca_sat(dneg3_q, SAT_W'(d3_q[DISC_W-1:FRAC_W]));

  always_comb begin
    st_d = qca_pkg::ST_OK;
    case (cmd3_q)
      qca_pkg::CMD_DIV: begin
        if (bm3_q == '0) st_d = qca_pkg::ST_DIV0;
      end
      qca_pkg::CMD_ROOTS: begin
        if (dneg3_q) st_d = qca_pkg::ST_NEGDISC;
        else if (am3_q == '0) st_d = qca_pkg::ST_DIV0;
      end
      qca_pkg::CMD_SQRT: begin
        if (an3_q) st_d = qca_pkg::ST_NEGROOT;
      end
      qca_pkg::CMD_INVALID: begin
        st_d = qca_pkg::ST_INVALID;
      end
      default: begin
        st_d = qca_pkg::ST_OK;
      end
    endcase
  end

  always_comb begin
    side_d       = '0;
    side_d.cmd   = cmd3_q;
    side_d.st    = st_d;
    side_d.a_neg = an3_q;
    side_d.b_neg = bn3_q;
    side_d.a_mag = am3_q;
    side_d.b_mag = bm3_q;
    side_d.b_val = b3_q;
    side_d.r_first = r3_q;
    side_d.ovf   = ovf3_q;
    if (cmd3_q == qca_pkg::CMD_DISC || cmd3_q == qca_pkg::CMD_ROOTS) begin
      side_d.dout = dsat.val;
      side_d.ovf  = dsat.ovf;
    end
    if (cmd3_q == qca_pkg::CMD_DISC) side_d.r_first = dsat.val;
  end

  assign sq_x_d = (cmd3_q == qca_pkg::CMD_SQRT) ? SQ_IN_W'({am3_q, {FRAC_W{1'b0}}})
                                                : SQ_IN_W'(d3_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= valid_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cmd0_q  <= qca_pkg::qca_cmd_e'(command_i);
      an0_q   <= operand_a_i[DATA_W-1];
      bn0_q   <= operand_b_i[DATA_W-1];
      cn0_q   <= operand_c_i[DATA_W-1];
      am0_q   <= am_d;
      bm0_q   <= bm_d;
      cm0_q   <= cm_d;
      a0_q    <= operand_a_i;
      b0_q    <= operand_b_i;

      cmd1_q  <= cmd0_q;
      an1_q   <= an0_q;
      bn1_q   <= bn0_q;
      cn1_q   <= cn0_q;
      am1_q   <= am0_q;
      bm1_q   <= bm0_q;
      b1_q    <= b0_q;
      pbb1_q  <= bm0_q * bm0_q;
      pab1_q  <= am0_q * bm0_q;
      pac1_q  <= am0_q * cm0_q;
      sum1_q  <= (DATA_W+1)'(a0_q) + (DATA_W+1)'(b0_q);
      dif1_q  <= (DATA_W+1)'(a0_q) - (DATA_W+1)'(b0_q);

      cmd2_q  <= cmd1_q;
      an2_q   <= an1_q;
      bn2_q   <= bn1_q;
      am2_q   <= am1_q;
      bm2_q   <= bm1_q;
      b2_q    <= b1_q;
      r2_q    <= r2_d;
      ovf2_q  <= ovf2_d;
      qneg2_q <= (an1_q ^ cn1_q) && (pac1_q != '0);
      dsum2_q <= DISC_W'(pbb1_q) + DISC_W'(q4);
      ddif2_q <= (DISC_W+1)'(pbb1_q) - (DISC_W+1)'(q4);

      cmd3_q  <= cmd2_q;
      an3_q   <= an2_q;
      bn3_q   <= bn2_q;
      am3_q   <= am2_q;
      bm3_q   <= bm2_q;
      b3_q    <= b2_q;
      r3_q    <= r2_q;
      ovf3_q  <= ovf2_q;
      d3_q    <= d3_d;
      dneg3_q <= !qneg2_q && ddif2_q[DISC_W];

      side_q  <= side_d;
      sq_x_q  <= sq_x_d;
    end
  end

  assign valid_o = v4_q;
  assign side_o  = side_q;
  assign sq_x_o  = sq_x_q;

endmodule

### hdl/qca_sqrt.sv
module qca_sqrt (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  qca_pkg::qca_side_t           side_i,
  input  logic [qca_pkg::SQ_IN_W-1:0]  x_i,
  output logic                         valid_o,
  output qca_pkg::qca_side_t           side_o,
  output logic [qca_pkg::ROOT_W-1:0]   root_o
);

  localparam int ROOT_W   = qca_pkg::ROOT_W;
  localparam int SQ_IN_W  = qca_pkg::SQ_IN_W;
  localparam int SQ_REM_W = qca_pkg::SQ_REM_W;

  // one result bit per stage, two operand bits brought down each time
  logic                  v_q    [ROOT_W];
  qca_pkg::qca_side_t    side_q [ROOT_W];
  logic [SQ_IN_W-1:0]    x_q    [ROOT_W];
  logic [SQ_REM_W-1:0]   rem_q  [ROOT_W];
  logic [ROOT_W-1:0]     root_q [ROOT_W];

  logic [SQ_IN_W-1:0]    x_in   [ROOT_W];
  logic [SQ_REM_W-1:0]   rem_in [ROOT_W];
  logic [ROOT_W-1:0]     root_in[ROOT_W];
  logic [SQ_IN_W-1:0]    x_d    [ROOT_W];
  logic [SQ_REM_W-1:0]   rem_d  [ROOT_W];
  logic [ROOT_W-1:0]     root_d [ROOT_W];
  logic [SQ_REM_W+1:0]   sh     [ROOT_W];
  logic [SQ_REM_W+1:0]   trial  [ROOT_W];
  logic                  fits   [ROOT_W];

  always_comb begin
    x_in[0]    = x_i;
    rem_in[0]  = '0;
    root_in[0] = '0;
    for (int k = 1; k < ROOT_W; k++) begin
      x_in[k]    = x_q[k-1];
      rem_in[k]  = rem_q[k-1];
      root_in[k] = root_q[k-1];
    end
    for (int k = 0; k < ROOT_W; k++) begin
      sh[k]     = {rem_in[k], x_in[k][SQ_IN_W-1 -: 2]};
      trial[k]  = (SQ_REM_W+2)'({root_in[k], 2'b01});
      fits[k]   = sh[k] >= trial[k];
      rem_d[k]  = fits[k] ? SQ_REM_W'(sh[k] - trial[k]) : SQ_REM_W'(sh[k]);
      root_d[k] = {root_in[k][ROOT_W-2:0], fits[k]};
      x_d[k]    = x_in[k] << 2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < ROOT_W; k++) v_q[k] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
      for (int k = 1; k < ROOT_W; k++) v_q[k] <= v_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      for (int k = 1; k < ROOT_W; k++) side_q[k] <= side_q[k-1];
      for (int k = 0; k < ROOT_W; k++) begin
        x_q[k]    <= x_d[k];
        rem_q[k]  <= rem_d[k];
        root_q[k] <= root_d[k];
      end
    end
  end

  assign valid_o = v_q[ROOT_W-1];
  assign side_o  = side_q[ROOT_W-1];
  assign root_o  = root_q[ROOT_W-1];

endmodule

### hdl/qca_prep.sv
module qca_prep (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  qca_pkg::qca_side_t          side_i,
  input  logic [qca_pkg::ROOT_W-1:0]  root_i,
  output logic                        valid_o,
  output qca_pkg::qca_side_t          side_o,
  output logic [qca_pkg::NUM_W-1:0]   num1_o,
  output logic [qca_pkg::NUM_W-1:0]   num2_o,
  output logic [qca_pkg::DEN_W-1:0]   den_o
);

  localparam int DATA_W = qca_pkg::DATA_W;
  localparam int FRAC_W = qca_pkg::FRAC_W;
  localparam int DIFF_W = qca_pkg::DIFF_W;
  localparam int MAGN_W = qca_pkg::MAGN_W;
  localparam int NUM_W  = qca_pkg::NUM_W;
  localparam int DEN_W  = qca_pkg::DEN_W;

  logic                       v0_q, v1_q;
  qca_pkg::qca_side_t         s0_d, s0_q, s1_d, s1_q;
  logic signed [DIFF_W-1:0]   n1_q, n2_q;
  logic [MAGN_W-1:0]          m1, m2;
  logic                       is_div;
  logic [NUM_W-1:0]           num1_d, num1_q, num2_d, num2_q;
  logic [DEN_W-1:0]           den_d, den_q;

  // the sqrt result goes straight out as the answer
  always_comb begin
    s0_d = side_i;
    if (side_i.cmd == qca_pkg::CMD_SQRT) s0_d.r_first = root_i[DATA_W-1:0];
  end

  assign is_div = (s0_q.cmd == qca_pkg::CMD_DIV);
  assign m1     = n1_q[DIFF_W-1] ? MAGN_W'(-n1_q) : MAGN_W'(n1_q);
  assign m2     = n2_q[DIFF_W-1] ? MAGN_W'(-n2_q) : MAGN_W'(n2_q);

  always_comb begin
    s1_d = s0_q;
    if (is_div) begin
      num1_d    = NUM_W'({s0_q.a_mag, {FRAC_W{1'b0}}});
      den_d     = DEN_W'(s0_q.b_mag);
      s1_d.neg1 = s0_q.a_neg ^ s0_q.b_neg;
    end else begin
      num1_d    = {m1, {FRAC_W{1'b0}}};
      den_d     = {s0_q.a_mag, 1'b0};
      s1_d.neg1 = n1_q[DIFF_W-1] ^ s0_q.a_neg;
    end
    num2_d    = {m2, {FRAC_W{1'b0}}};
    s1_d.neg2 = n2_q[DIFF_W-1] ^ s0_q.a_neg;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= valid_i;
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s0_q   <= s0_d;
      n1_q   <= DIFF_W'(root_i) - DIFF_W'($signed(side_i.b_val));
      n2_q   <= -DIFF_W'(root_i) - DIFF_W'($signed(side_i.b_val));
      s1_q   <= s1_d;
      num1_q <= num1_d;
      num2_q <= num2_d;
      den_q  <= den_d;
    end
  end

  assign valid_o = v1_q;
  assign side_o  = s1_q;
  assign num1_o  = num1_q;
  assign num2_o  = num2_q;
  assign den_o   = den_q;

endmodule

### hdl/qca_div.sv
module qca_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  qca_pkg::qca_side_t         side_i,
  input  logic [qca_pkg::NUM_W-1:0]  num1_i,
  input  logic [qca_pkg::NUM_W-1:0]  num2_i,
  input  logic [qca_pkg::DEN_W-1:0]  den_i,
  output logic                       valid_o,
  output qca_pkg::qca_side_t         side_o,
  output logic [qca_pkg::NUM_W-1:0]  quo1_o,
  output logic [qca_pkg::NUM_W-1:0]  quo2_o
);

  localparam int NUM_W = qca_pkg::NUM_W;
  localparam int DEN_W = qca_pkg::DEN_W;

  // restoring division, one quotient bit per stage, two lanes on one divisor;
  // the quotient bits shift into the numerator word
  logic                v_q    [NUM_W];
  qca_pkg::qca_side_t  side_q [NUM_W];
  logic [DEN_W-1:0]    den_q  [NUM_W];
  logic [NUM_W-1:0]    w1_q   [NUM_W];
  logic [NUM_W-1:0]    w2_q   [NUM_W];
  logic [DEN_W-1:0]    r1_q   [NUM_W];
  logic [DEN_W-1:0]    r2_q   [NUM_W];

  logic [DEN_W-1:0]    den_in [NUM_W];
  logic [NUM_W-1:0]    w1_in  [NUM_W];
  logic [NUM_W-1:0]    w2_in  [NUM_W];
  logic [DEN_W-1:0]    r1_in  [NUM_W];
  logic [DEN_W-1:0]    r2_in  [NUM_W];
  logic [DEN_W:0]      sh1    [NUM_W];
  logic [DEN_W:0]      sh2    [NUM_W];
  logic                f1     [NUM_W];
  logic                f2     [NUM_W];
  logic [NUM_W-1:0]    w1_d   [NUM_W];
  logic [NUM_W-1:0]    w2_d   [NUM_W];
  logic [DEN_W-1:0]    r1_d   [NUM_W];
  logic [DEN_W-1:0]    r2_d   [NUM_W];

  always_comb begin
    den_in[0] = den_i;
    w1_in[0]  = num1_i;
    w2_in[0]  = num2_i;
    r1_in[0]  = '0;
    r2_in[0]  = '0;
    for (int k = 1; k < NUM_W; k++) begin
      den_in[k] = den_q[k-1];
      w1_in[k]  = w1_q[k-1];
      w2_in[k]  = w2_q[k-1];
      r1_in[k]  = r1_q[k-1];
      r2_in[k]  = r2_q[k-1];
    end
    for (int k = 0; k < NUM_W; k++) begin
      sh1[k]  = {r1_in[k], w1_in[k][NUM_W-1]};
      sh2[k]  = {r2_in[k], w2_in[k][NUM_W-1]};
      f1[k]   = sh1[k] >= {1'b0, den_in[k]};
      f2[k]   = sh2[k] >= {1'b0, den_in[k]};
      r1_d[k] = f1[k] ? DEN_W'(sh1[k] - {1'b0, den_in[k]}) : sh1[k][DEN_W-1:0];
      r2_d[k] = f2[k] ? DEN_W'(sh2[k] - {1'b0, den_in[k]}) : sh2[k][DEN_W-1:0];
      w1_d[k] = {w1_in[k][NUM_W-2:0], f1[k]};
      w2_d[k] = {w2_in[k][NUM_W-2:0], f2[k]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_W; k++) v_q[k] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
      for (int k = 1; k < NUM_W; k++) v_q[k] <= v_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      for (int k = 1; k < NUM_W; k++) side_q[k] <= side_q[k-1];
      for (int k = 0; k < NUM_W; k++) begin
        den_q[k] <= den_in[k];
        w1_q[k]  <= w1_d[k];
        w2_q[k]  <= w2_d[k];
        r1_q[k]  <= r1_d[k];
        r2_q[k]  <= r2_d[k];
      end
    end
  end

  assign valid_o = v_q[NUM_W-1];
  assign side_o  = side_q[NUM_W-1];
  assign quo1_o  = w1_q[NUM_W-1];
  assign quo2_o  = w2_q[NUM_W-1];

endmodule

### hdl/quadratic_calculator_alu.sv
// Channel   Handshake                  Payload
// request   in_valid_i / in_ready_o    command_i, operand_a_i, operand_b_i, operand_c_i
// result    out_valid_o / out_ready_i  result_first_o, result_second_o,
//                                      discriminant_out_o, status_o
//
// One request enters per cycle while in_ready_o is high; each result passes through
// 93 register stages: 5 front stages, 34 square-root stages (one root bit each),
// 2 numerator stages, 51 divider stages (one quotient bit each), 1 output register.
// Reset (rst_ni low, asynchronous) empties every stage; no clearing pass is needed.
// A stalled result freezes the whole pipeline in place; in_ready_o is high whenever
// the output register is empty or being taken, so nothing is dropped or repeated.
`include "quadratic_calculator_alu_macros.svh"

module quadratic_calculator_alu (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [qca_pkg::CMD_W-1:0]         command_i,
  input  logic signed [qca_pkg::DATA_W-1:0] operand_a_i,
  input  logic signed [qca_pkg::DATA_W-1:0] operand_b_i,
  input  logic signed [qca_pkg::DATA_W-1:0] operand_c_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [qca_pkg::DATA_W-1:0] result_first_o,
  output logic signed [qca_pkg::DATA_W-1:0] result_second_o,
  output logic signed [qca_pkg::DATA_W-1:0] discriminant_out_o,
  output logic [qca_pkg::ST_W-1:0]          status_o
);

  localparam int DATA_W   = qca_pkg::DATA_W;
  localparam int SAT_W    = qca_pkg::SAT_W;
  localparam int ROOT_W   = qca_pkg::ROOT_W;
  // a square root of a Q value never reaches this bit
  localparam int SQRT_TOP = (qca_pkg::DATA_W + qca_pkg::FRAC_W) / 2;

  logic                             adv;
  logic                             fr_v, sq_v, pr_v, dv_v;
  qca_pkg::qca_side_t               fr_side, sq_side, pr_side, dv_side;
  logic [qca_pkg::SQ_IN_W-1:0]      sq_x;
  logic [ROOT_W-1:0]                sq_root;
  logic [qca_pkg::NUM_W-1:0]        num1, num2, quo1, quo2;
  logic [qca_pkg::DEN_W-1:0]        den;

  qca_pkg::qca_sat_t                sat1, sat2;
  logic                             use_div, is_roots, ovf;
  logic [DATA_W-1:0]                res1_d, res2_d, disc_d;
  qca_pkg::qca_status_e             st_d;

  logic                             out_valid_q;
  logic [DATA_W-1:0]                res1_q, res2_q, disc_q;
  qca_pkg::qca_status_e             st_q;

  // advance the whole pipeline unless a finished result is held back
  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  qca_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (adv),
    .valid_i     (in_valid_i),
    .command_i   (command_i),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .operand_c_i (operand_c_i),
    .valid_o     (fr_v),
    .side_o      (fr_side),
    .sq_x_o      (sq_x)
  );

  // shared root unit: discriminant for the roots, a << FRAC for sqrt
  qca_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (fr_v),
    .side_i  (fr_side),
    .x_i     (sq_x),
    .valid_o (sq_v),
    .side_o  (sq_side),
    .root_o  (sq_root)
  );

  qca_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (sq_v),
    .side_i  (sq_side),
    .root_i  (sq_root),
    .valid_o (pr_v),
    .side_o  (pr_side),
    .num1_o  (num1),
    .num2_o  (num2),
    .den_o   (den)
  );

  // lane 1 serves divide and x1, lane 2 serves x2
  qca_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (pr_v),
    .side_i  (pr_side),
    .num1_i  (num1),
    .num2_i  (num2),
    .den_i   (den),
    .valid_o (dv_v),
    .side_o  (dv_side),
    .quo1_o  (quo1),
    .quo2_o  (quo2)
  );

  // final clamp and result select
  assign sat1     = qca_pkg::qca_sat(dv_side.neg1, SAT_W'(quo1));
  assign sat2     = qca_pkg::qca_sat(dv_side.neg2, SAT_W'(quo2));
  assign is_roots = (dv_side.cmd == qca_pkg::CMD_ROOTS);
  assign use_div  = (dv_side.cmd == qca_pkg::CMD_DIV) || is_roots;
  assign ovf      = dv_side.ovf || (use_div && sat1.ovf) || (is_roots && sat2.ovf);

  always_comb begin
    res1_d = use_div ? sat1.val : dv_side.r_first;
    res2_d = is_roots ? sat2.val : '0;
    disc_d = dv_side.dout;
    st_d   = ovf ? qca_pkg::ST_SAT : qca_pkg::ST_OK;
    // any error drops all values to zero
    if (dv_side.st != qca_pkg::ST_OK) begin
      res1_d = '0;
      res2_d = '0;
      disc_d = '0;
      st_d   = dv_side.st;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= dv_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res1_q <= res1_d;
      res2_q <= res2_d;
      disc_q <= disc_d;
      st_q   <= st_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign result_first_o     = res1_q;
  assign result_second_o    = res2_q;
  assign discriminant_out_o = disc_q;
  assign status_o           = st_q;

  `QCA_ASSERT_IMPL(a_err_zero, out_valid_o && (status_o == qca_pkg::ST_DIV0 || status_o == qca_pkg::ST_NEGDISC || status_o == qca_pkg::ST_NEGROOT || status_o == qca_pkg::ST_INVALID), result_first_o == '0 && result_second_o == '0 && discriminant_out_o == '0, "error result carries nonzero values")
  `QCA_ASSERT_NEXT(a_stall_hold, !adv, $stable(dv_v) && $stable(dv_side) && $stable(quo1), "divider moved during a stall")
  `QCA_ASSERT_IMPL(a_sqrt_range, sq_v && sq_side.cmd == qca_pkg::CMD_SQRT, sq_root[ROOT_W-1:SQRT_TOP] == '0, "square root exceeds operand range")

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import qca_pkg::*;

  typedef struct {
    qca_cmd_e          cmd;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic [DATA_W-1:0] c;
  } calc_req_t;

  typedef struct {
    logic [DATA_W-1:0] first;
    logic [DATA_W-1:0] second;
    logic [DATA_W-1:0] disc;
    qca_status_e       st;
  } calc_res_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [CMD_W-1:0]  command = '0;
  logic [DATA_W-1:0] op_a = '0;
  logic [DATA_W-1:0] op_b = '0;
  logic [DATA_W-1:0] op_c = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [DATA_W-1:0] res_first;
  logic [DATA_W-1:0] res_second;
  logic [DATA_W-1:0] res_disc;
  logic [ST_W-1:0]   res_status;

  calc_req_t pending_reqs[$];
  calc_res_t expected_results[$];
  int        send_idle_pct = 27;
  int        recv_idle_pct = 85;
  int        errors = 0;
  int        results_seen = 0;
  int        status_hits[8];

  quadratic_calculator_alu dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .command_i          (command),
    .operand_a_i        (op_a),
    .operand_b_i        (op_b),
    .operand_c_i        (op_c),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .result_first_o     (res_first),
    .result_second_o    (res_second),
    .discriminant_out_o (res_disc),
    .status_o           (res_status)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Clamp a sign/magnitude value into the signed 32-bit range; flag any clipping.
  function automatic logic [DATA_W-1:0] clamp(input bit neg, input logic [127:0] mag,
                                              inout bit ovf);
    if (mag == 0) return '0;
    if (!neg) begin
      if (mag > 128'h7fff_ffff) begin
        ovf = 1'b1;
        return 32'h7fff_ffff;
      end
      return mag[DATA_W-1:0];
    end
    if (mag > 128'h8000_0000) begin
      ovf = 1'b1;
      return 32'h8000_0000;
    end
    return (~mag[DATA_W-1:0]) + 32'd1;
  endfunction

  // Floor of the square root, one bit at a time from the top.
  function automatic logic [63:0] floor_sqrt(input logic [127:0] x);
    logic [63:0]  r;
    logic [63:0]  t;
    logic [127:0] sq;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      t = r | (64'd1 << i);
      sq = 128'(t) * 128'(t);
      if (sq <= x) r = t;
    end
    return r;
  endfunction

  function automatic calc_res_t compute_result(input calc_req_t q);
    calc_res_t    r;
    bit           ovf;
    bit           an, bn, cn, dneg, qneg, ng1, ng2;
    logic [63:0]  am, bm, cm, root, den, m1, m2;
    longint       av, bv, sum, n1, n2;
    logic [127:0] p, fq, d;
    r.first = '0;
    r.second = '0;
    r.disc = '0;
    r.st = ST_OK;
    ovf = 1'b0;
    an = q.a[DATA_W-1];
    bn = q.b[DATA_W-1];
    cn = q.c[DATA_W-1];
    am = an ? 64'(-$signed({1'b1, q.a})) : 64'(q.a);
    bm = bn ? 64'(-$signed({1'b1, q.b})) : 64'(q.b);
    cm = cn ? 64'(-$signed({1'b1, q.c})) : 64'(q.c);
    av = longint'($signed(q.a));
    bv = longint'($signed(q.b));
    case (q.cmd)
      CMD_ADD, CMD_SUB: begin
        sum = (q.cmd == CMD_ADD) ? av + bv : av - bv;
        r.first = clamp(sum < 0, (sum < 0) ? 128'(-sum) : 128'(sum), ovf);
      end
      CMD_DIV: begin
        if (bm == 0) r.st = ST_DIV0;
        else r.first = clamp(an != bn, (128'(am) << FRAC_W) / 128'(bm), ovf);
      end
      CMD_MUL: r.first = clamp(an != bn, (128'(am) * 128'(bm)) >> FRAC_W, ovf);
      CMD_DISC, CMD_ROOTS: begin
        p = 128'(bm) * 128'(bm);
        fq = (128'(am) * 128'(cm)) << 2;
        qneg = (an != cn) && (fq != 0);
        if (qneg) begin
          d = p + fq;
          dneg = 1'b0;
        end else if (p >= fq) begin
          d = p - fq;
          dneg = 1'b0;
        end else begin
          d = fq - p;
          dneg = 1'b1;
        end
        if (q.cmd == CMD_DISC) begin
          r.disc = clamp(dneg, d >> FRAC_W, ovf);
          r.first = r.disc;
        end else if (dneg) begin
          r.st = ST_NEGDISC;
        end else if (am == 0) begin
          r.st = ST_DIV0;
        end else begin
          root = floor_sqrt(d);
          den = am << 1;
          n1 = longint'(root) - bv;
          n2 = -longint'(root) - bv;
          ng1 = n1 < 0;
          ng2 = n2 < 0;
          m1 = ng1 ? 64'(-n1) : 64'(n1);
          m2 = ng2 ? 64'(-n2) : 64'(n2);
          r.disc = clamp(1'b0, d >> FRAC_W, ovf);
          r.first = clamp(ng1 != an, (128'(m1) << FRAC_W) / 128'(den), ovf);
          r.second = clamp(ng2 != an, (128'(m2) << FRAC_W) / 128'(den), ovf);
        end
      end
      CMD_SQRT: begin
        if (an) r.st = ST_NEGROOT;
        else r.first = clamp(1'b0, 128'(floor_sqrt(128'(am) << FRAC_W)), ovf);
      end
      default: r.st = ST_INVALID;
    endcase
    if (r.st != ST_OK) begin
      r.first = '0;
      r.second = '0;
      r.disc = '0;
    end else if (ovf) begin
      r.st = ST_SAT;
    end
    return r;
  endfunction

  // Sender: advance to the next request once the current one is taken.
  always @(posedge clk_i or negedge rst_ni) begin
    calc_req_t cur;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        cur.cmd = qca_cmd_e'(command);
        cur.a = op_a;
        cur.b = op_b;
        cur.c = op_c;
        expected_results.push_back(compute_result(cur));
      end
      // hold the payload while a request is still waiting
      if (!in_valid || in_ready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur = pending_reqs.pop_front();
          command <= cur.cmd;
          op_a <= cur.a;
          op_b <= cur.b;
          op_c <= cur.c;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random backpressure, check each taken result against the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    calc_res_t want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding");
          errors++;
        end else begin
          want = expected_results.pop_front();
          status_hits[want.st]++;
          if (res_first !== want.first) begin
            $error("result_first: expected %h actual %h", want.first, res_first);
            errors++;
          end
          if (res_second !== want.second) begin
            $error("result_second: expected %h actual %h", want.second, res_second);
            errors++;
          end
          if (res_disc !== want.disc) begin
            $error("discriminant_out: expected %h actual %h", want.disc, res_disc);
            errors++;
          end
          if (res_status !== want.st) begin
            $error("status: expected %0d actual %0d", want.st, res_status);
            errors++;
          end
        end
      end
    end
  end

  function automatic logic [DATA_W-1:0] pick_operand();
    case ($urandom_range(5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 400)) - 200) << FRAC_W;
      2: return 32'($signed($urandom_range(0, 32'h01ff_ffff)) - 32'h0100_0000);
      3: begin
        case ($urandom_range(4))
          0: return 32'h7fff_ffff;
          1: return 32'h8000_0000;
          2: return 32'hffff_ffff;
          3: return 32'h0000_0001;
          default: return '0;
        endcase
      end
      default: return 32'($signed($urandom_range(0, 2000)) - 1000) << 12;
    endcase
  endfunction

  task automatic queue_req(input qca_cmd_e cmd, input logic [DATA_W-1:0] a,
                           input logic [DATA_W-1:0] b, input logic [DATA_W-1:0] c);
    calc_req_t q;
    q.cmd = cmd;
    q.a = a;
    q.b = b;
    q.c = c;
    pending_reqs.push_back(q);
  endtask

  task automatic queue_random(input int count);
    logic [DATA_W-1:0] a, b, c;
    qca_cmd_e          cmd;
    for (int i = 0; i < count; i++) begin
      cmd = qca_cmd_e'($urandom_range(7));
      a = pick_operand();
      b = pick_operand();
      c = pick_operand();
      // mostly well-formed quadratics: nonzero a, c of opposite sign gives real roots
      if (cmd == CMD_ROOTS && $urandom_range(3) != 0) begin
        a = 32'($signed($urandom_range(1, 40))) << ($urandom_range(8, 16));
        if ($urandom_range(1)) a = -a;
        if ($urandom_range(2) != 0) c = a[DATA_W-1] ? c & 32'h7fff_ffff : c | 32'h8000_0000;
      end
      queue_req(cmd, a, b, c);
    end
  endtask

  task automatic drain();
    while (pending_reqs.size() != 0 || expected_results.size() != 0 || in_valid)
      @(posedge clk_i);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed corners
    queue_req(CMD_ADD, 32'h7fff_ffff, 32'h7fff_ffff, 0);
    queue_req(CMD_ADD, 32'h8000_0000, 32'h8000_0000, 0);
    queue_req(CMD_SUB, 32'h8000_0000, 32'h0000_0001, 0);
    queue_req(CMD_SUB, 32'h0003_0000, 32'h0001_8000, 0);
    queue_req(CMD_DIV, 32'h0001_0000, 32'h0000_0000, 0);
    queue_req(CMD_DIV, 32'h8000_0000, 32'hffff_0000, 0);
    queue_req(CMD_DIV, 32'hfff9_0000, 32'h0002_0000, 0);
    queue_req(CMD_MUL, 32'h7fff_ffff, 32'h7fff_ffff, 0);
    queue_req(CMD_MUL, 32'h8000_0000, 32'h0001_0000, 0);
    queue_req(CMD_MUL, 32'hfffe_8000, 32'h0002_0000, 0);
    queue_req(CMD_DISC, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    queue_req(CMD_DISC, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
    queue_req(CMD_ROOTS, 32'h0001_0000, 32'hfffd_0000, 32'h0002_0000);
    queue_req(CMD_ROOTS, 32'h0001_0000, 32'h0000_0000, 32'h0001_0000);
    queue_req(CMD_ROOTS, 32'h0000_0000, 32'h0002_0000, 32'h0001_0000);
    queue_req(CMD_ROOTS, 32'hfffe_0000, 32'h7fff_ffff, 32'h7fff_ffff);
    queue_req(CMD_ROOTS, 32'h0000_0001, 32'h8000_0000, 32'h8000_0000);
    queue_req(CMD_SQRT, 32'h0004_0000, 0, 0);
    queue_req(CMD_SQRT, 32'h7fff_ffff, 0, 0);
    queue_req(CMD_SQRT, 32'hffff_ffff, 0, 0);
    queue_req(CMD_INVALID, 32'h1234_5678, 32'h8765_4321, 32'hffff_ffff);

    queue_random(300);
    drain();
    send_idle_pct = 85;
    recv_idle_pct = 27;
    queue_random(300);
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(300);
    drain();

    repeat (150) @(posedge clk_i);
    $display("Checked %0d results over all seven commands plus the invalid code;",
             results_seen);
    $display("status counts ok/div0/negdisc/negroot/invalid/sat: %0d %0d %0d %0d %0d %0d",
             status_hits[0], status_hits[1], status_hits[2], status_hits[3],
             status_hits[4], status_hits[5]);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

### filelist.f
+incdir+hdl
hdl/qca_pkg.sv
hdl/qca_front.sv
hdl/qca_sqrt.sv
hdl/qca_prep.sv
hdl/qca_div.sv
hdl/quadratic_calculator_alu.sv
sim/testbench.sv
